>>> sv/fault_status_led_and_link_sequencer_top_assert.svh
// Assertion macros for the fault status lamp and link sequencer.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef FAULT_STATUS_LED_AND_LINK_SEQUENCER_TOP_ASSERT_SVH
`define FAULT_STATUS_LED_AND_LINK_SEQUENCER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define FSLS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fsls check failed");

`define FSLS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("fsls check failed");

`else

`define FSLS_ASSERT(label, prop)

`define FSLS_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> sv/fsls_pkg.sv
// Shared constants, codes and structs for the fault status lamp and link sequencer.
// No dependencies.
`timescale 1ns / 1ps

package fsls_pkg;

  localparam int unsigned BLINK_DIV   = 50;
  localparam int unsigned REPORT_DIV  = 1000;
  localparam int unsigned BPHASE_W    = $clog2(BLINK_DIV + 1);
  localparam int unsigned RPHASE_W    = $clog2(REPORT_DIV + 1);

  localparam logic [BPHASE_W-1:0] BLINK_LAST  = BPHASE_W'(BLINK_DIV - 1);
  localparam logic [RPHASE_W-1:0] REPORT_LAST = RPHASE_W'(REPORT_DIV - 1);

  localparam logic [15:0] ON_TICKS    = 16'd1000;
  localparam logic [15:0] START_TICKS = 16'd6000;
  localparam logic [6:0]  SAMPLE_LAST = 7'd100;
  localparam logic [13:0] BLINK_WRAP  = 14'd10000;
  localparam logic [18:0] TEMP_GAIN   = 19'd500;
  localparam logic [9:0]  ADC_FULL    = 10'd1023;
  localparam logic [8:0]  THR_RESET   = 9'd100;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_CONNECT = 2'd1;
  localparam logic [1:0] REQ_OFF     = 2'd2;

  localparam logic [1:0] LINK_OFF      = 2'd0;
  localparam logic [1:0] LINK_STARTING = 2'd1;
  localparam logic [1:0] LINK_ON       = 2'd2;

  localparam logic [1:0] ALERT_NONE   = 2'd0;
  localparam logic [1:0] ALERT_DOOR   = 2'd1;
  localparam logic [1:0] ALERT_NOZZLE = 2'd2;
  localparam logic [1:0] ALERT_TEMP   = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        door_open;
    logic        inlet_removed;
    logic        nozzle_jam;
    logic [18:0] temp_prod;
    logic [9:0]  supply_raw;
  } item_t;

  typedef struct packed {
    logic       lamp_green;
    logic       led_red;
    logic       alarm_out;
    logic       fan_on;
    logic       supply_high;
    logic       sensor_on;
    logic [1:0] link_mode;
    logic [1:0] alert_code;
    logic       err_report;
    logic       adc_report;
    logic [9:0] adc_value;
  } result_t;

endpackage

>>> sv/fsls_seq.sv
// Per-item state update: sampling, fault classification, lamps, reports, link sequencer.
// Depends on fsls_pkg.
`timescale 1ns / 1ps

module fsls_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  fsls_pkg::item_t   item_i,
  input  logic [8:0]        threshold_i,
  output fsls_pkg::result_t result_o
);

  logic [6:0]                    sample_q, sample_d, sample_inc;
  logic [8:0]                    temp_scaled_q, temp_scaled_d;
  logic [1:0]                    alert_q, alert_d;
  logic [1:0]                    prev_alert_q, prev_alert_d;
  logic [13:0]                   blink_q, blink_d, blink_inc;
  logic [fsls_pkg::BPHASE_W-1:0] bphase_q, bphase_d;
  logic [fsls_pkg::RPHASE_W-1:0] rphase_q, rphase_d;
  logic                          green_q, green_d;
  logic                          red_q, red_d;
  logic [15:0]                   link_count_q, link_count_d, link_inc;
  logic [1:0]                    link_state_q, link_state_d;
  logic                          fan_q, fan_d;
  logic                          supply_q, supply_d;
  logic                          sensor_q, sensor_d;
  logic                          fault_off, blink_edge;
  logic                          err, adc;
  logic [9:0]                    adc_val;

  // temp_prod / 1023 via reciprocal 1025 / 2^20 and one correction step
  logic [28:0] recip_prod;
  logic [8:0]  quot_est;
  logic [19:0] quot_rem;
  logic [8:0]  temp_quot;

  assign recip_prod = {10'b0, item_i.temp_prod} + {item_i.temp_prod, 10'b0};
  assign quot_est   = recip_prod[28:20];
  assign quot_rem   = {1'b0, item_i.temp_prod} - ({1'b0, quot_est, 10'b0} - {11'b0, quot_est});
  assign temp_quot  = (quot_rem >= {10'b0, fsls_pkg::ADC_FULL}) ? quot_est + 9'd1 : quot_est;

  always_comb begin
    sample_d      = sample_q;
    temp_scaled_d = temp_scaled_q;
    alert_d       = alert_q;
    prev_alert_d  = prev_alert_q;
    blink_d       = blink_q;
    bphase_d      = bphase_q;
    rphase_d      = rphase_q;
    green_d       = green_q;
    red_d         = red_q;
    link_count_d  = link_count_q;
    link_state_d  = link_state_q;
    fan_d         = fan_q;
    supply_d      = supply_q;
    sensor_d      = sensor_q;
    sample_inc    = sample_q + 7'd1;
    blink_inc     = blink_q + 14'd1;
    link_inc      = 16'd0;
    fault_off     = 1'b0;
    blink_edge    = 1'b0;
    err           = 1'b0;
    adc           = 1'b0;
    adc_val       = 10'd0;

    case (item_i.req_type)
      fsls_pkg::REQ_CONNECT: begin
        link_count_d = 16'd0;
        fan_d        = 1'b0;
        supply_d     = 1'b1;
        link_state_d = fsls_pkg::LINK_STARTING;
      end
      fsls_pkg::REQ_OFF: begin
        link_count_d = 16'd0;
        supply_d     = 1'b0;
        fan_d        = 1'b0;
        sensor_d     = 1'b0;
        link_state_d = fsls_pkg::LINK_OFF;
      end
      fsls_pkg::REQ_TICK: begin
        if (sample_inc > fsls_pkg::SAMPLE_LAST) begin
          sample_d      = 7'd0;
          temp_scaled_d = temp_quot;
        end else begin
          sample_d = sample_inc;
        end

        if (item_i.door_open || item_i.inlet_removed) begin
          alert_d   = fsls_pkg::ALERT_DOOR;
          fault_off = 1'b1;
        end else if (item_i.nozzle_jam) begin
          alert_d   = fsls_pkg::ALERT_NOZZLE;
          fault_off = 1'b1;
        end else if (temp_scaled_d >= threshold_i) begin
          alert_d   = fsls_pkg::ALERT_TEMP;
          fault_off = 1'b1;
        end else begin
          alert_d = fsls_pkg::ALERT_NONE;
        end
        if (fault_off) begin
          link_count_d = 16'd0;
          supply_d     = 1'b0;
          fan_d        = 1'b0;
          sensor_d     = 1'b0;
          link_state_d = fsls_pkg::LINK_OFF;
        end

        // keep phase counters equal to blink_count modulo each divider
        if (blink_inc >= fsls_pkg::BLINK_WRAP) begin
          blink_d  = 14'd0;
          bphase_d = '0;
          rphase_d = '0;
        end else begin
          blink_d  = blink_inc;
          bphase_d = (bphase_q == fsls_pkg::BLINK_LAST) ? '0 : bphase_q + 1'b1;
          rphase_d = (rphase_q == fsls_pkg::REPORT_LAST) ? '0 : rphase_q + 1'b1;
        end
        blink_edge = (bphase_d == '0);

        case (alert_d)
          fsls_pkg::ALERT_NONE: begin
            green_d = 1'b1;
            red_d   = 1'b0;
          end
          fsls_pkg::ALERT_NOZZLE: begin
            if (blink_edge) begin
              green_d = ~green_q;
              red_d   = ~green_q;
            end
          end
          fsls_pkg::ALERT_TEMP: begin
            if (blink_edge) begin
              green_d = ~green_q;
            end
            red_d = 1'b0;
          end
          default: begin
            if (blink_edge) begin
              red_d = ~red_q;
            end
            green_d = 1'b0;
          end
        endcase

        if (alert_d != fsls_pkg::ALERT_NONE && rphase_d == '0) begin
          err          = 1'b1;
          supply_d     = 1'b0;
          prev_alert_d = alert_d;
        end else if (alert_d == fsls_pkg::ALERT_NONE &&
                     prev_alert_q != fsls_pkg::ALERT_NONE) begin
          err          = 1'b1;
          prev_alert_d = fsls_pkg::ALERT_NONE;
        end

        link_inc = link_count_d + 16'd1;
        if (link_inc >= fsls_pkg::ON_TICKS && link_state_d == fsls_pkg::LINK_ON) begin
          link_count_d = 16'd0;
          adc          = 1'b1;
          adc_val      = item_i.supply_raw;
        end else if (link_inc >= fsls_pkg::START_TICKS &&
                     link_state_d == fsls_pkg::LINK_STARTING) begin
          fan_d        = 1'b1;
          supply_d     = 1'b0;
          sensor_d     = 1'b1;
          link_count_d = 16'd0;
          link_state_d = fsls_pkg::LINK_ON;
        end else if (link_inc >= fsls_pkg::START_TICKS) begin
          link_count_d = 16'd0;
        end else begin
          link_count_d = link_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q      <= '0;
      temp_scaled_q <= '0;
      alert_q       <= fsls_pkg::ALERT_NONE;
      prev_alert_q  <= fsls_pkg::ALERT_NONE;
      blink_q       <= '0;
      bphase_q      <= '0;
      rphase_q      <= '0;
      green_q       <= 1'b0;
      red_q         <= 1'b0;
      link_count_q  <= '0;
      link_state_q  <= fsls_pkg::LINK_OFF;
      fan_q         <= 1'b0;
      supply_q      <= 1'b0;
      sensor_q      <= 1'b0;
    end else if (step_i) begin
      sample_q      <= sample_d;
      temp_scaled_q <= temp_scaled_d;
      alert_q       <= alert_d;
      prev_alert_q  <= prev_alert_d;
      blink_q       <= blink_d;
      bphase_q      <= bphase_d;
      rphase_q      <= rphase_d;
      green_q       <= green_d;
      red_q         <= red_d;
      link_count_q  <= link_count_d;
      link_state_q  <= link_state_d;
      fan_q         <= fan_d;
      supply_q      <= supply_d;
      sensor_q      <= sensor_d;
    end
  end

  assign result_o.lamp_green  = green_d;
  assign result_o.led_red     = red_d;
  assign result_o.alarm_out   = red_d;
  assign result_o.fan_on      = fan_d;
  assign result_o.supply_high = supply_d;
  assign result_o.sensor_on   = sensor_d;
  assign result_o.link_mode   = link_state_d;
  assign result_o.alert_code  = alert_d;
  assign result_o.err_report  = err;
  assign result_o.adc_report  = adc;
  assign result_o.adc_value   = adc_val;

endmodule

>>> sv/fault_status_led_and_link_sequencer_top.sv
// Top level: stream ports, input and result registers, threshold register.
// Depends on fsls_pkg, fsls_seq and fault_status_led_and_link_sequencer_top_assert.svh.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid_i/tready_o       tdata 24b, tuser 2b (req_type)
//   m_axis    out  m_axis_tvalid_o/tready_i       tdata 24b
//   cfg       in   cfg_we_i                       cfg_wdata_i 9b (temp_threshold)
//
// One transfer in and one result out per cycle, sustained while m_axis does not stall.
// An item passes through the input register, then the state update into the result register.
// Reset clears the sequencer state and valid flags and sets the threshold to 100.
// A stall on m_axis holds the result register; the input register fills and then
// s_axis_tready_o drops.
`timescale 1ns / 1ps

`include "fault_status_led_and_link_sequencer_top_assert.svh"

module fault_status_led_and_link_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // door_open, inlet_removed, nozzle_jam, temp_raw[9:0], supply_raw[9:0], pad
  input  logic [23:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // lamp_green, led_red, alarm_out, fan_on, supply_high, sensor_on, link_mode[1:0],
  // alert_code[1:0], err_report, adc_report, adc_value[9:0], pad[1:0]
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);

  logic              in_valid_q;
  fsls_pkg::item_t   item_q;
  logic              out_valid_q;
  fsls_pkg::result_t out_q;
  fsls_pkg::result_t result;
  logic [8:0]        thr_q;
  logic              advance;
  logic              s_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= fsls_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      item_q.req_type      <= s_axis_tuser_i;
      item_q.door_open     <= s_axis_tdata_i[0];
      item_q.inlet_removed <= s_axis_tdata_i[1];
      item_q.nozzle_jam    <= s_axis_tdata_i[2];
      item_q.temp_prod     <= {9'b0, s_axis_tdata_i[12:3]} * fsls_pkg::TEMP_GAIN;
      item_q.supply_raw    <= s_axis_tdata_i[22:13];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  fsls_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item_q),
    .threshold_i (thr_q),
    .result_o    (result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.adc_value, out_q.adc_report, out_q.err_report,
                            out_q.alert_code, out_q.link_mode, out_q.sensor_on,
                            out_q.supply_high, out_q.fan_on, out_q.alarm_out,
                            out_q.led_red, out_q.lamp_green};

  `FSLS_ASSERT(a_on_mode_outputs, (m_axis_tvalid_o && out_q.link_mode == fsls_pkg::LINK_ON) |-> (out_q.fan_on && out_q.sensor_on && !out_q.supply_high))
  `FSLS_ASSERT(a_adc_only_on, (m_axis_tvalid_o && out_q.adc_report) |-> (out_q.link_mode == fsls_pkg::LINK_ON && !out_q.err_report))
  `FSLS_ASSERT(a_adc_value_idle, (m_axis_tvalid_o && !out_q.adc_report) |-> (out_q.adc_value == 10'd0))
  `FSLS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!in_valid_q || $past(rst_ni) == 1'b1))

endmodule
